// ===== rtl/text_console_cursor_scroll_assert.svh =====
// Assertion macros used by the console sequencer
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TCC_ASSERT_IMP(lbl, clk, rst, a, b) \
lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
// next-cycle implication
`define TCC_ASSERT_NXT(lbl, clk, rst, a, b) \
lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`endif

// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console.
// ----------------------------------------------------------------------------
`default_nettype none
package tcc_pkg;
   localparam int GridRows = 20;
   localparam int GridCols = 30;
   localparam int RowW = 5;
   localparam int ColW = 5;
   localparam int Cells = GridRows * GridCols;
   localparam int AddrW = $clog2(Cells);
   localparam int CellW = 40;
   localparam logic [7:0] ChNewline = 8'd10;
   localparam logic [7:0] ChReturn = 8'd13;
   localparam logic [7:0] ChSpace = 8'd32;

   localparam logic [1:0] OpPut = 2'd0;
   localparam logic [1:0] OpRead = 2'd1;
   localparam logic [1:0] OpHome = 2'd2;

   localparam logic [1:0] RegFg = 2'd0;
   localparam logic [1:0] RegBg = 2'd1;
   localparam logic [1:0] RegMode = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_RDWAIT, ST_CLEAR, ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [4:0] read_col;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [4:0]  cursor_col;
      logic [7:0]  cell_char;
      logic [15:0] cell_fg;
      logic [15:0] cell_bg;
      logic        scrolled;
      logic        wrapped_top;
   } rsp_type;

   // memory write/read request from sequencer
   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [CellW-1:0] wdata;
      logic [AddrW-1:0] raddr;
   } mem_ctl_type;

   function automatic logic [AddrW-1:0] cell_addr(logic [RowW-1:0] r, logic [ColW-1:0] c);
      return AddrW'(r * GridCols + c);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/tcc_if.sv =====
// ----------------------------------------------------------------------------
// tcc_req_if / tcc_rsp_if
// Valid/ready channels of the text console.
// ----------------------------------------------------------------------------
`default_nettype none
interface tcc_req_if;
   logic valid;
   logic ready;
   tcc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tcc_rsp_if;
   logic valid;
   logic ready;
   tcc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/tcc_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcc_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tcc_cell_ram (
   input  wire logic                clock,
   input  wire tcc_pkg::mem_ctl_type ctl,
   output logic [tcc_pkg::CellW-1:0] rdata
);
   import tcc_pkg::*;
   logic [CellW-1:0] mem [Cells];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata <= mem[ctl.raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/tcc_seq.sv =====
// ----------------------------------------------------------------------------
// tcc_seq
// Sequencer: cursor, ring offset, row clearing, start-up RAM clear and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cursor_scroll_assert.svh"
module tcc_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           fg_color,
   input  wire logic [15:0]           bg_color,
   input  wire logic                  end_mode,
   tcc_req_if.sink                    req,
   tcc_rsp_if.source                  rsp,
   output tcc_pkg::mem_ctl_type       mem_ctl,
   input  wire logic [tcc_pkg::CellW-1:0] mem_rdata
);
   import tcc_pkg::*;

   state_type state_ff, state_in;
   logic [RowW-1:0] row_ff, row_in, top_ff, top_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] clr_row_ff, clr_row_in;   // physical row being cleared
   logic [ColW-1:0] clr_col_ff, clr_col_in;
   logic [AddrW-1:0] init_ff, init_in;
   logic scr_ff, scr_in, wrap_ff, wrap_in, rd_ok_ff, rd_ok_in;
   rsp_type out_ff, out_in;

   logic [RowW:0] ph_cur_sum, ph_rd_sum, ph_nx_sum;
   logic [RowW-1:0] ph_cur, ph_rd, ph_next, top_inc;
   logic [CellW-1:0] blank;
   logic last_col, last_row;

   // ring arithmetic: (top + r) mod rows, operands below rows
   assign ph_cur_sum = {1'b0, top_ff} + {1'b0, row_ff};
   assign ph_cur = (ph_cur_sum >= (RowW+1)'(GridRows)) ?
                   RowW'(ph_cur_sum - (RowW+1)'(GridRows)) : RowW'(ph_cur_sum);
   assign ph_rd_sum = {1'b0, top_ff} + {1'b0, req.payload.read_row};
   assign ph_rd = (ph_rd_sum >= (RowW+1)'(GridRows)) ?
                  RowW'(ph_rd_sum - (RowW+1)'(GridRows)) : RowW'(ph_rd_sum);
   assign ph_nx_sum = {1'b0, ph_cur} + (RowW+1)'(1);
   assign ph_next = (ph_nx_sum >= (RowW+1)'(GridRows)) ? '0 : RowW'(ph_nx_sum);
   assign top_inc = (top_ff == RowW'(GridRows - 1)) ? '0 : top_ff + RowW'(1);
   assign last_col = (col_ff >= ColW'(GridCols - 1));
   assign last_row = (row_ff >= RowW'(GridRows - 1));
   assign blank = {ChSpace, fg_color, bg_color};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (init_ff == AddrW'(Cells - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req.valid) begin
               unique case (req.payload.opcode)
                  OpPut: begin
                     if (req.payload.char_code == ChNewline)
                        state_in = (last_row) ? ST_CLEAR : ST_DONE;
                     else if (req.payload.char_code == ChReturn) state_in = ST_DONE;
                     else state_in = last_col ? ST_CLEAR : ST_DONE;
                  end
                  OpRead: state_in = ST_RDWAIT;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RDWAIT: state_in = ST_DONE;
         ST_CLEAR: if (clr_col_ff == ColW'(GridCols - 1)) state_in = ST_DONE;
         ST_DONE: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      top_in = top_ff;
      clr_row_in = clr_row_ff;
      clr_col_in = clr_col_ff;
      init_in = init_ff;
      scr_in = scr_ff;
      wrap_in = wrap_ff;
      rd_ok_in = rd_ok_ff;
      out_in = out_ff;
      mem_ctl.we = 1'b0;
      mem_ctl.waddr = cell_addr(ph_cur, col_ff);
      mem_ctl.wdata = {req.payload.char_code, fg_color, bg_color};
      mem_ctl.raddr = cell_addr(ph_rd, req.payload.read_col);
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_DONE);
      rsp.payload = out_ff;
      unique case (state_ff)
         ST_INIT: begin
            mem_ctl.we = 1'b1;
            mem_ctl.waddr = init_ff;
            mem_ctl.wdata = '0;
            init_in = init_ff + AddrW'(1);
         end
         ST_IDLE: begin
            scr_in = 1'b0;
            wrap_in = 1'b0;
            clr_col_in = '0;
            rd_ok_in = (req.payload.read_row < RowW'(GridRows)) &&
                       (req.payload.read_col < ColW'(GridCols));
            if (req.valid) begin
               unique case (req.payload.opcode)
                  OpPut: begin
                     if (req.payload.char_code == ChReturn) begin
                        col_in = '0;
                     end else begin
                        if (req.payload.char_code != ChNewline) mem_ctl.we = 1'b1;
                        if (req.payload.char_code == ChNewline || last_col) begin
                           col_in = '0;
                           if (!last_row) begin
                              row_in = row_ff + RowW'(1);
                              clr_row_in = ph_next;
                           end else if (!end_mode) begin
                              top_in = top_inc;
                              clr_row_in = top_ff;    // old top becomes new bottom
                              scr_in = 1'b1;
                           end else begin
                              row_in = '0;
                              clr_row_in = top_ff;
                              wrap_in = 1'b1;
                           end
                        end else begin
                           col_in = col_ff + ColW'(1);
                        end
                     end
                  end
                  OpHome: begin
                     row_in = '0;
                     col_in = '0;
                  end
                  default: ;
               endcase
               out_in = '0;
            end
         end
         ST_CLEAR: begin
            mem_ctl.we = 1'b1;
            mem_ctl.waddr = cell_addr(clr_row_ff, clr_col_ff);
            mem_ctl.wdata = blank;
            clr_col_in = clr_col_ff + ColW'(1);
         end
         default: ;
      endcase
      // result assembled while not yet shown
      if (state_ff != ST_DONE && state_ff != ST_INIT) begin
         out_in.cursor_row = row_in;
         out_in.cursor_col = col_in;
         out_in.scrolled = scr_in;
         out_in.wrapped_top = wrap_in;
         if (state_ff == ST_RDWAIT && rd_ok_ff) begin
            {out_in.cell_char, out_in.cell_fg, out_in.cell_bg} = mem_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff <= '0;
         col_ff <= '0;
         top_ff <= '0;
         init_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         top_ff <= top_in;
         init_ff <= init_in;
      end
      clr_row_ff <= clr_row_in;
      clr_col_ff <= clr_col_in;
      scr_ff <= scr_in;
      wrap_ff <= wrap_in;
      rd_ok_ff <= rd_ok_in;
      out_ff <= out_in;
   end

   `TCC_ASSERT_IMP(a_row_range, clock, reset, 1'b1, row_ff < RowW'(GridRows))
   `TCC_ASSERT_IMP(a_top_range, clock, reset, 1'b1, top_ff < RowW'(GridRows))
   `TCC_ASSERT_IMP(a_flags_excl, clock, reset, rsp.valid,
                   !(rsp.payload.scrolled && rsp.payload.wrapped_top))
   `TCC_ASSERT_NXT(a_rd_then_done, clock, reset, state_ff == ST_RDWAIT, state_ff == ST_DONE)
endmodule
`default_nettype wire

// ===== rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console grid with cursor, row ring scrolling and cell reads.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// req_    | in  | valid/ready        | opcode, char_code, read_row, read_col
// rsp_    | out | valid/ready        | cursor, cell, scrolled, wrapped_top
// csr_    | in  | csr_we             | index, 16-bit data
// Put/home/nop items pass IDLE, DONE; reads pass IDLE, RDWAIT, DONE. A put that
// wraps past the last column, or a newline on the bottom row, passes CLEAR to
// blank a row through the single cell RAM write port; a newline above the bottom
// adds no clear. After reset a pass zeroes all GridRows*GridCols (600) cells; no
// item is accepted then. The next item is taken once the result is consumed.
`default_nettype none
module text_console_cursor_scroll (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   tcc_req_if.sink          req,
   tcc_rsp_if.source        rsp
);
   import tcc_pkg::*;
   logic [15:0] fg_ff, bg_ff;
   logic mode_ff;
   mem_ctl_type mem_ctl;
   logic [CellW-1:0] mem_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= 16'hFFFF;
         bg_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            RegFg: fg_ff <= csr_wdata;
            RegBg: bg_ff <= csr_wdata;
            RegMode: mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tcc_seq u_seq (
      .clock(clock), .reset(reset), .fg_color(fg_ff), .bg_color(bg_ff),
      .end_mode(mode_ff), .req(req), .rsp(rsp), .mem_ctl(mem_ctl),
      .mem_rdata(mem_rdata)
   );

   tcc_cell_ram u_ram (.clock(clock), .ctl(mem_ctl), .rdata(mem_rdata));
endmodule
`default_nettype wire
